// ===== hdl/morse_symbol_tone_keyer_unit_macros.svh =====
// Assertion macros for the Morse tone keyer.
`ifndef MORSE_SYMBOL_TONE_KEYER_UNIT_MACROS_SVH
`define MORSE_SYMBOL_TONE_KEYER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSTK_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("keyer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MSTK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("keyer assertion failed");

`endif

// ===== hdl/mstk_pkg.sv =====
`default_nettype none

package mstk_pkg;

	localparam int DIT_BITS_DEF = 16;
	localparam int HALF_PERIOD_BITS_DEF = 16;

	localparam int DIT_RESET = 800;
	localparam int HALF_PERIOD_RESET = 10;

	localparam int CFG_INDEX_BITS = 1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_DIT_LENGTH = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_HALF_PERIOD = 1'b1;

	localparam logic [7:0] CODE_DOT = 8'h2E;
	localparam logic [7:0] CODE_DASH = 8'h2D;
	localparam logic [7:0] CODE_SPACE = 8'h20;
	localparam logic [7:0] CODE_NEWLINE = 8'h0A;

	localparam logic [7:0] LEVEL_SILENCE = 8'd128;
	localparam logic [7:0] LEVEL_HIGH = 8'd255;
	localparam logic [7:0] LEVEL_LOW = 8'd0;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_GAP,
		MODE_TONE,
		MODE_SILENT
	} mode_t;

	typedef struct packed {
		logic [7:0] sample;
		logic       symbol_taken;
		logic       bad_symbol;
		logic       busy_res;
	} mstk_result_t;

endpackage

`default_nettype wire

// ===== hdl/mstk_cfg_regs.sv =====
`default_nettype none

module mstk_cfg_regs
	import mstk_pkg::*;
#(
	parameter int DIT_BITS = DIT_BITS_DEF,
	parameter int HALF_PERIOD_BITS = HALF_PERIOD_BITS_DEF,
	parameter int CFG_W = (DIT_BITS > HALF_PERIOD_BITS) ? DIT_BITS : HALF_PERIOD_BITS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [CFG_INDEX_BITS-1:0]   cfg_index,
	input  wire logic [CFG_W-1:0]            cfg_data,
	output logic      [DIT_BITS-1:0]         dit_len,
	output logic      [HALF_PERIOD_BITS-1:0] half_period
);

	logic [DIT_BITS-1:0]         dit_len_q;
	logic [HALF_PERIOD_BITS-1:0] half_period_q;
	logic [DIT_BITS-1:0]         dit_wr;
	logic [HALF_PERIOD_BITS-1:0] hp_wr;

	// A written zero behaves as one, so the stored value is already the effective one.
	assign dit_wr = cfg_data[DIT_BITS-1:0];
	assign hp_wr = cfg_data[HALF_PERIOD_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dit_len_q <= DIT_BITS'(DIT_RESET);
			half_period_q <= HALF_PERIOD_BITS'(HALF_PERIOD_RESET);
		end else if (cfg_we) begin
			if (cfg_index == CFG_DIT_LENGTH) begin
				dit_len_q <= (dit_wr == '0) ? DIT_BITS'(1) : dit_wr;
			end
			if (cfg_index == CFG_HALF_PERIOD) begin
				half_period_q <= (hp_wr == '0) ? HALF_PERIOD_BITS'(1) : hp_wr;
			end
		end
	end

	assign dit_len = dit_len_q;
	assign half_period = half_period_q;

endmodule

`default_nettype wire

// ===== hdl/mstk_keyer_core.sv =====
`default_nettype none

module mstk_keyer_core
	import mstk_pkg::*;
#(
	parameter int DIT_BITS = DIT_BITS_DEF,
	parameter int HALF_PERIOD_BITS = HALF_PERIOD_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step_en,
	input  wire logic                        symbol_valid,
	input  wire logic [7:0]                  symbol_code,
	input  wire logic [DIT_BITS-1:0]         dit_len,
	input  wire logic [HALF_PERIOD_BITS-1:0] half_period,
	output mstk_result_t                     result
);

	localparam int REM_W = DIT_BITS + 3;
	localparam int PEND_W = DIT_BITS + 2;

	mode_t                       mode_q, mode_d;
	logic [REM_W-1:0]            remaining_q, remaining_d;
	logic [PEND_W-1:0]           pending_q, pending_d;
	logic [HALF_PERIOD_BITS-1:0] half_cnt_q, half_cnt_d;
	logic                        tone_low_q, tone_low_d;
	logic                        line_start_q, line_start_d;

	logic [PEND_W-1:0]           dit_x3;
	logic [REM_W-1:0]            dit_x7;
	logic [PEND_W-1:0]           mark_len;
	logic                        is_mark;
	logic [HALF_PERIOD_BITS:0]   half_cnt_inc;

	assign dit_x3 = {1'b0, dit_len, 1'b0} + {2'b00, dit_len};
	assign dit_x7 = {dit_len, 3'b000} - {3'b000, dit_len};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			remaining_q <= '0;
			pending_q <= '0;
			half_cnt_q <= '0;
			tone_low_q <= 1'b0;
			line_start_q <= 1'b1;
		end else if (step_en) begin
			mode_q <= mode_d;
			remaining_q <= remaining_d;
			pending_q <= pending_d;
			half_cnt_q <= half_cnt_d;
			tone_low_q <= tone_low_d;
			line_start_q <= line_start_d;
		end
	end

	always_comb begin
		mode_d = mode_q;
		remaining_d = remaining_q;
		pending_d = pending_q;
		half_cnt_d = half_cnt_q;
		tone_low_d = tone_low_q;
		line_start_d = line_start_q;
		mark_len = '0;
		is_mark = 1'b0;
		half_cnt_inc = '0;
		result = '{sample: LEVEL_SILENCE, symbol_taken: 1'b0, bad_symbol: 1'b0,
			busy_res: 1'b0};

		// A symbol is only looked at while nothing is playing.
		if (mode_q == MODE_IDLE && symbol_valid) begin
			result.symbol_taken = 1'b1;
			unique case (symbol_code)
				CODE_DOT: begin
					is_mark = 1'b1;
					mark_len = {2'b00, dit_len};
				end
				CODE_DASH: begin
					is_mark = 1'b1;
					mark_len = dit_x3;
				end
				CODE_SPACE: begin
					mode_d = MODE_SILENT;
					remaining_d = {1'b0, dit_x3};
					line_start_d = 1'b0;
				end
				CODE_NEWLINE: begin
					mode_d = MODE_SILENT;
					remaining_d = dit_x7;
					line_start_d = 1'b1;
				end
				default: begin
					result.symbol_taken = 1'b0;
					result.bad_symbol = 1'b1;
				end
			endcase
		end

		// A mark at the start of a line skips the leading one-dit gap.
		if (is_mark) begin
			if (line_start_q) begin
				mode_d = MODE_TONE;
				remaining_d = {1'b0, mark_len};
				half_cnt_d = '0;
				tone_low_d = 1'b0;
			end else begin
				mode_d = MODE_GAP;
				remaining_d = {3'b000, dit_len};
				pending_d = mark_len;
			end
			line_start_d = 1'b0;
		end

		if (mode_d != MODE_IDLE) begin
			result.busy_res = 1'b1;
			if (mode_d == MODE_TONE) begin
				result.sample = tone_low_d ? LEVEL_LOW : LEVEL_HIGH;
				half_cnt_inc = {1'b0, half_cnt_d} + (HALF_PERIOD_BITS + 1)'(1);
				if (half_cnt_inc >= {1'b0, half_period}) begin
					half_cnt_d = '0;
					tone_low_d = !tone_low_d;
				end else begin
					half_cnt_d = half_cnt_inc[HALF_PERIOD_BITS-1:0];
				end
			end
			if (remaining_d != '0) begin
				remaining_d = remaining_d - REM_W'(1);
			end
			if (remaining_d == '0) begin
				if (mode_d == MODE_GAP) begin
					// The gap hands over to the tone it was holding back.
					mode_d = (pending_d == '0) ? MODE_IDLE : MODE_TONE;
					remaining_d = {1'b0, pending_d};
					half_cnt_d = '0;
					tone_low_d = 1'b0;
					pending_d = '0;
				end else begin
					mode_d = MODE_IDLE;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/morse_symbol_tone_keyer_unit.sv =====
// Morse symbol tone keyer.
//
// Input channel: in_valid / in_stall with payload symbol_valid and symbol_code.
// Every input beat is one audio sample tick and gives exactly one output beat.
// Output channel: out_valid / out_stall with sample, symbol_taken, bad_symbol
// and busy_res. A symbol is taken only when no earlier symbol is still playing;
// otherwise symbol_taken is 0 and the source offers it again on a later beat.
// Configuration: cfg_we writes cfg_data into the register selected by
// cfg_index (0 dit length, 1 tone half period, both in samples).
// A beat is registered in the input stage and its result in the output stage.
// One beat is accepted every cycle while in_stall is low; the keyer state
// register is updated once per beat by a single combinational pass between stages.
// Reset loads a dit of 800 and a half period of 10, empties both stages and
// leaves the keyer idle at the start of a line.
// When the receiver stalls, the output stage holds its beat, one more beat
// waits in the input stage, and then in_stall is raised.
`default_nettype none

`include "morse_symbol_tone_keyer_unit_macros.svh"

module morse_symbol_tone_keyer_unit
	import mstk_pkg::*;
#(
	parameter int DIT_BITS = DIT_BITS_DEF,
	parameter int HALF_PERIOD_BITS = HALF_PERIOD_BITS_DEF,
	localparam int CFG_W = (DIT_BITS > HALF_PERIOD_BITS) ? DIT_BITS : HALF_PERIOD_BITS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic                      symbol_valid,
	input  wire logic [7:0]                symbol_code,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic      [7:0]                sample,
	output logic                           symbol_taken,
	output logic                           bad_symbol,
	output logic                           busy_res,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]          cfg_data
);

	logic                        valid_s1;
	logic                        symbol_valid_s1;
	logic [7:0]                  symbol_code_s1;
	logic                        valid_s2;
	mstk_result_t                result_s2;
	mstk_result_t                step_result;
	logic                        out_free;
	logic                        s1_move;
	logic [DIT_BITS-1:0]         dit_len;
	logic [HALF_PERIOD_BITS-1:0] half_period;

	assign out_free = !valid_s2 || !out_stall;
	assign s1_move = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	mstk_cfg_regs #(
		.DIT_BITS(DIT_BITS),
		.HALF_PERIOD_BITS(HALF_PERIOD_BITS),
		.CFG_W(CFG_W)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.dit_len(dit_len),
		.half_period(half_period)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			symbol_valid_s1 <= symbol_valid;
			symbol_code_s1 <= symbol_code;
		end
	end

	mstk_keyer_core #(
		.DIT_BITS(DIT_BITS),
		.HALF_PERIOD_BITS(HALF_PERIOD_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step_en(s1_move),
		.symbol_valid(symbol_valid_s1),
		.symbol_code(symbol_code_s1),
		.dit_len(dit_len),
		.half_period(half_period),
		.result(step_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= s1_move;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			result_s2 <= step_result;
		end
	end

	assign out_valid = valid_s2;
	assign sample = result_s2.sample;
	assign symbol_taken = result_s2.symbol_taken;
	assign bad_symbol = result_s2.bad_symbol;
	assign busy_res = result_s2.busy_res;

	`MSTK_ASSERT_SAME(a_taken_bad_excl, clk, arst_n, out_valid, !(symbol_taken && bad_symbol))
	`MSTK_ASSERT_SAME(a_idle_silent, clk, arst_n, out_valid && !busy_res, sample == LEVEL_SILENCE)
	`MSTK_ASSERT_SAME(a_bad_not_busy, clk, arst_n, out_valid && bad_symbol, !busy_res)
	`MSTK_ASSERT_NEXT(a_move_fills_out, clk, arst_n, s1_move, out_valid)

endmodule

`default_nettype wire

// ===== dv/keyer_sample_checker.sv =====
`timescale 1ns / 100ps

module keyer_sample_checker
	import mstk_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        symbol_valid,
	input  logic [7:0]  symbol_code,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  sample,
	input  logic        symbol_taken,
	input  logic        bad_symbol,
	input  logic        busy_res,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending
);

	// Keyer state, kept at the widths of the block.
	mode_t       key_mode;
	logic [18:0] left_cnt;
	logic [17:0] tone_len_pend;
	logic [15:0] half_cnt;
	logic        level_low;
	logic        line_start;
	logic [15:0] dit_reg;
	logic [15:0] half_reg;

	mstk_result_t tick_results_due[$];
	int           n_fail;

	// A dit length or half period of zero behaves as one.
	function automatic logic [15:0] at_least_one(input logic [15:0] x);
		return (x == 16'd0) ? 16'd1 : x;
	endfunction

	function automatic void start_tone(input logic [17:0] len);
		key_mode = MODE_TONE;
		left_cnt = 19'(len);
		half_cnt = 16'd0;
		level_low = 1'b0;
	endfunction

	function automatic void start_mark(input logic [17:0] len);
		if (line_start) begin
			start_tone(len);
		end else begin
			key_mode = MODE_GAP;
			left_cnt = 19'(at_least_one(dit_reg));
			tone_len_pend = len;
		end
		line_start = 1'b0;
	endfunction

	// One sample tick: takes the offered symbol if idle and returns the sample.
	function automatic mstk_result_t key_tick(input logic offered, input logic [7:0] code);
		mstk_result_t r;
		logic [15:0]  d;
		d = at_least_one(dit_reg);
		r.sample = LEVEL_SILENCE;
		r.symbol_taken = 1'b0;
		r.bad_symbol = 1'b0;
		r.busy_res = 1'b0;
		if (key_mode == MODE_IDLE && offered) begin
			r.symbol_taken = 1'b1;
			case (code)
				CODE_DOT: start_mark(18'(d));
				CODE_DASH: start_mark(18'(d) * 18'd3);
				CODE_SPACE: begin
					key_mode = MODE_SILENT;
					left_cnt = 19'(d) * 19'd3;
					line_start = 1'b0;
				end
				CODE_NEWLINE: begin
					key_mode = MODE_SILENT;
					left_cnt = 19'(d) * 19'd7;
					line_start = 1'b1;
				end
				default: begin
					r.symbol_taken = 1'b0;
					r.bad_symbol = 1'b1;
				end
			endcase
		end
		if (key_mode != MODE_IDLE) begin
			r.busy_res = 1'b1;
			if (key_mode == MODE_TONE) begin
				r.sample = level_low ? LEVEL_LOW : LEVEL_HIGH;
				half_cnt = half_cnt + 16'd1;
				if (half_cnt >= at_least_one(half_reg)) begin
					half_cnt = 16'd0;
					level_low = !level_low;
				end
			end
			if (left_cnt != 19'd0)
				left_cnt = left_cnt - 19'd1;
			if (left_cnt == 19'd0) begin
				if (key_mode == MODE_GAP) begin
					start_tone(tone_len_pend);
					tone_len_pend = 18'd0;
					if (left_cnt == 19'd0)
						key_mode = MODE_IDLE;
				end else begin
					key_mode = MODE_IDLE;
				end
			end
		end
		return r;
	endfunction

	function automatic void report(input string field, input int want_v, input int got_v);
		$display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
		n_fail++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mstk_result_t want;
		mstk_result_t got;
		if (!arst_n) begin
			key_mode = MODE_IDLE;
			left_cnt = 19'd0;
			tone_len_pend = 18'd0;
			half_cnt = 16'd0;
			level_low = 1'b0;
			line_start = 1'b1;
			dit_reg = 16'(DIT_RESET);
			half_reg = 16'(HALF_PERIOD_RESET);
			tick_results_due.delete();
			n_fail = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_DIT_LENGTH: dit_reg = cfg_data;
					CFG_HALF_PERIOD: half_reg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				tick_results_due.push_back(key_tick(symbol_valid, symbol_code));
			if (out_valid && !out_stall) begin
				got = {sample, symbol_taken, bad_symbol, busy_res};
				if (tick_results_due.size() == 0) begin
					$display("%0t: output beat expected none, got sample %0d",
						$time, got.sample);
					n_fail++;
				end else begin
					want = tick_results_due.pop_front();
					if (got.sample !== want.sample)
						report("sample", want.sample, got.sample);
					if (got.symbol_taken !== want.symbol_taken)
						report("symbol_taken", want.symbol_taken, got.symbol_taken);
					if (got.bad_symbol !== want.bad_symbol)
						report("bad_symbol", want.bad_symbol, got.bad_symbol);
					if (got.busy_res !== want.busy_res)
						report("busy_res", want.busy_res, got.busy_res);
				end
			end
			pending <= tick_results_due.size();
			fail_count <= n_fail;
		end
	end

endmodule

// ===== dv/morse_symbol_tone_keyer_unit_tb.sv =====
`timescale 1ns / 100ps

module morse_symbol_tone_keyer_unit_tb;
	import mstk_pkg::*;

	localparam int HOLD_OFF_CYCLES = 400;
	localparam int LIMIT_CYCLES = 2_000_000;
	localparam logic [15:0] FULL_SCALE = 16'hFFFF;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        symbol_valid;
	logic [7:0]  symbol_code;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  sample;
	logic        symbol_taken;
	logic        bad_symbol;
	logic        busy_res;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;

	int n_fail;
	int n_pending;
	int n_beats = 0;
	int n_taken = 0;
	int n_bad = 0;
	int cycle_cnt = 0;
	int snd_idle_pct = 0;
	int rcv_stall_pct = 0;
	int hold_req = 0;
	int hold_done = 0;
	int hold_left = 0;

	logic [15:0] dit_set [5];
	logic [15:0] hp_set [5];

	always #5 clk = ~clk;

	morse_symbol_tone_keyer_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.symbol_valid(symbol_valid),
		.symbol_code (symbol_code),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.sample      (sample),
		.symbol_taken(symbol_taken),
		.bad_symbol  (bad_symbol),
		.busy_res    (busy_res),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	keyer_sample_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.symbol_valid(symbol_valid),
		.symbol_code (symbol_code),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.sample      (sample),
		.symbol_taken(symbol_taken),
		.bad_symbol  (bad_symbol),
		.busy_res    (busy_res),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (n_fail),
		.pending     (n_pending)
	);

	// Receiver: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_done) begin
			hold_done <= hold_req;
			hold_left <= HOLD_OFF_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rcv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			n_taken <= n_taken + symbol_taken;
			n_bad <= n_bad + bad_symbol;
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT_CYCLES) begin
			$display("Timed out after %0d cycles", cycle_cnt);
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_beat(input logic offered, input logic [7:0] code);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			symbol_code <= 8'($urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		symbol_valid <= offered;
		symbol_code <= code;
		do
			@(posedge clk);
		while (in_stall);
		n_beats++;
	endtask

	// Stops offering and waits until every beat sent has come back.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (n_pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_keyer(input logic [15:0] dit, input logic [15:0] hp);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= CFG_DIT_LENGTH;
		cfg_data <= dit;
		@(posedge clk);
		cfg_index <= CFG_HALF_PERIOD;
		cfg_data <= hp;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_traffic(input int sel);
		case (sel)
			0: begin
				snd_idle_pct = 23;
				rcv_stall_pct <= 78;
			end
			1: begin
				snd_idle_pct = 78;
				rcv_stall_pct <= 23;
			end
			default: begin
				snd_idle_pct = 0;
				rcv_stall_pct <= 0;
			end
		endcase
	endtask

	initial begin
		int          p;
		int          r;
		int          nb_start;
		int          hold_max;
		logic [7:0]  code;
		logic        held;
		logic        paused;
		arst_n = 1'b0;
		in_valid = 1'b0;
		symbol_valid = 1'b0;
		symbol_code = 8'd0;
		cfg_we = 1'b0;
		cfg_index = CFG_DIT_LENGTH;
		cfg_data = 16'd0;
		dit_set = '{16'd0, 16'd3, 16'd5, 16'd2, 16'd4};
		hp_set = '{16'd0, 16'd2, FULL_SCALE, 16'd3, 16'd1};
		held = 1'b0;
		paused = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_traffic(0);
		// Right after reset: an idle tick and two unknown bytes at the code extremes.
		send_beat(1'b0, CODE_DOT);
		send_beat(1'b1, 8'hFF);
		send_beat(1'b1, 8'h00);
		program_keyer(16'd1, 16'd1);
		// Marks, spaces and newlines at and away from line start, held while the keyer is busy.
		send_beat(1'b1, CODE_DOT);
		repeat (4) send_beat(1'b1, CODE_DASH);
		repeat (3) send_beat(1'b1, CODE_SPACE);
		repeat (2) send_beat(1'b1, CODE_DOT);
		repeat (7) send_beat(1'b1, CODE_NEWLINE);
		repeat (3) send_beat(1'b1, CODE_DASH);
		send_beat(1'b1, 8'h00);
		send_beat(1'b1, 8'hFF);
		send_beat(1'b0, 8'hFF);

		for (p = 0; p < 5; p++) begin
			set_traffic((p < 2) ? 0 : (p < 4) ? 1 : 2);
			program_keyer(dit_set[p], hp_set[p]);
			hold_max = 8 * ((dit_set[p] == 16'd0) ? 1 : int'(dit_set[p])) + 2;
			nb_start = n_beats;
			while (n_beats - nb_start < 80) begin
				if (p == 3 && !held && n_beats - nb_start >= 50) begin
					held = 1'b1;
					hold_req <= hold_req + 1;
				end
				if (p == 2 && !paused && n_beats - nb_start >= 55) begin
					paused = 1'b1;
					drain();
				end
				r = $urandom_range(99);
				if (r < 12) begin
					send_beat(1'($urandom_range(1)), 8'($urandom));
				end else if (r < 22) begin
					repeat ($urandom_range(4, 1)) send_beat(1'b0, 8'($urandom));
				end else begin
					r = $urandom_range(99);
					code = (r < 35) ? CODE_DOT : (r < 65) ? CODE_DASH :
						(r < 85) ? CODE_SPACE : CODE_NEWLINE;
					repeat ($urandom_range(hold_max, 1)) send_beat(1'b1, code);
				end
			end
		end
		// Let the keyer go quiet, then end on a newline so the next mark starts a line.
		repeat (40) send_beat(1'b0, 8'($urandom));
		send_beat(1'b1, CODE_NEWLINE);
		repeat (30) send_beat(1'b0, 8'($urandom));

		// Widest lengths: a dot at line start, watched over its first samples.
		program_keyer(FULL_SCALE, FULL_SCALE);
		send_beat(1'b1, CODE_DOT);
		repeat (20) send_beat(1'b0, 8'($urandom));

		drain();
		repeat (20) @(posedge clk);
		$display("Sent %0d input beats over seven keyer settings; %0d symbols taken, %0d bad bytes.",
			n_beats, n_taken, n_bad);
		$display("Traffic mixed sender gaps, receiver stalls and a long hold-off; dits 0 to 65535.");
		if (n_fail == 0 && n_pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches, %0d beats still expected", n_fail, n_pending);
			$display("FAILURE");
		end
		$finish;
	end

endmodule
